@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/ubxd_pkg.sv @@
// types and constants shared by the deframer modules
package ubxd_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 7;
	localparam int IDX_W       = 6;
	localparam int FRAME_LEN_W = 16;
	localparam int SKIP_W      = 17;
	localparam int TDATA_W     = 48;
	localparam int TUSER_W     = 3;
	localparam int TDATA_PAD_W = TDATA_W - (3 * BYTE_W + LEN_W + BYTE_W + IDX_W);

	typedef enum logic [1:0] {
		ST_NONE     = 2'd0,
		ST_PASS     = 2'd1,
		ST_FRAME    = 2'd2,
		ST_OVERSIZE = 2'd3
	} status_t;

	typedef enum logic {
		CMD_SINGLE = 1'b0,
		CMD_RUN    = 1'b1
	} cmd_kind_t;

	// one command per accepted byte, handed from parser to emitter
	typedef struct packed {
		cmd_kind_t          kind;
		status_t            status;
		logic [BYTE_W-1:0]  pass_byte;
		logic [BYTE_W-1:0]  msg_class;
		logic [BYTE_W-1:0]  msg_id;
		logic [LEN_W-1:0]   payload_len;
	} cmd_t;

	// payload buffer write port
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		logic [BYTE_W-1:0]  data;
	} wr_t;

endpackage

@@ hw/rtl/ubxd_parser.sv @@
// frame parser: sync hunt, header capture, fletcher sum, payload writes
module ubxd_parser
	import ubxd_pkg::*;
#(
	parameter int MAX_PAYLOAD = 64,
	parameter int SYNC_FIRST  = 181,
	parameter int SYNC_SECOND = 98
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              run_busy,
	input  logic              cmd_take,
	output logic              cmd_valid,
	output cmd_t              cmd,
	output wr_t               wr
);

	localparam logic [BYTE_W-1:0]      SYNC1_B = BYTE_W'(SYNC_FIRST);
	localparam logic [BYTE_W-1:0]      SYNC2_B = BYTE_W'(SYNC_SECOND);
	localparam logic [FRAME_LEN_W-1:0] MAX_LEN = FRAME_LEN_W'(MAX_PAYLOAD);

	typedef enum logic [9:0] {
		PH_SYNC1   = 10'b00_0000_0001,
		PH_SYNC2   = 10'b00_0000_0010,
		PH_CLASS   = 10'b00_0000_0100,
		PH_ID      = 10'b00_0000_1000,
		PH_LEN_LO  = 10'b00_0001_0000,
		PH_LEN_HI  = 10'b00_0010_0000,
		PH_PAYLOAD = 10'b00_0100_0000,
		PH_CK_A    = 10'b00_1000_0000,
		PH_CK_B    = 10'b01_0000_0000,
		PH_SKIP    = 10'b10_0000_0000
	} phase_t;

	phase_t                   phase_q, phase_d;
	logic                     cmd_valid_q;
	cmd_t                     cmd_q, cmd_d;
	logic [BYTE_W-1:0]        class_q, class_d;
	logic [BYTE_W-1:0]        id_q, id_d;
	logic [FRAME_LEN_W-1:0]   len_q, len_d;
	logic [BYTE_W-1:0]        sum_a_q, sum_a_d;
	logic [BYTE_W-1:0]        sum_b_q, sum_b_d;
	logic [BYTE_W-1:0]        recv_a_q, recv_a_d;
	logic [LEN_W-1:0]         fill_q, fill_d;
	logic [SKIP_W-1:0]        skip_q, skip_d;
	logic                     accept;
	logic [BYTE_W-1:0]        add_a;
	logic [BYTE_W-1:0]        add_b;
	logic [FRAME_LEN_W-1:0]   full_len;
	logic [LEN_W-1:0]         fill_inc;
	logic [SKIP_W-1:0]        skip_dec;

	// interlock: no new byte while a command waits or a payload run reads the buffer
	assign in_ready = !cmd_valid_q && !run_busy;
	assign accept   = in_valid && in_ready;

	assign add_a    = sum_a_q + in_byte;
	assign add_b    = sum_b_q + add_a;
	assign full_len = {in_byte, len_q[BYTE_W-1:0]};
	assign fill_inc = fill_q + LEN_W'(1);
	assign skip_dec = skip_q - SKIP_W'(1);

	always_comb begin
		phase_d  = phase_q;
		class_d  = class_q;
		id_d     = id_q;
		len_d    = len_q;
		sum_a_d  = sum_a_q;
		sum_b_d  = sum_b_q;
		recv_a_d = recv_a_q;
		fill_d   = fill_q;
		skip_d   = skip_q;
		cmd_d    = '{kind: CMD_SINGLE, status: ST_NONE, pass_byte: '0,
			msg_class: '0, msg_id: '0, payload_len: '0};
		unique case (phase_q)
			PH_SYNC1: begin
				if (in_byte == SYNC1_B) begin
					phase_d = PH_SYNC2;
				end else begin
					cmd_d.status    = ST_PASS;
					cmd_d.pass_byte = in_byte;
				end
			end
			PH_SYNC2: begin
				if (in_byte == SYNC2_B) begin
					phase_d = PH_CLASS;
				end else if (in_byte != SYNC1_B) begin
					phase_d         = PH_SYNC1;
					cmd_d.status    = ST_PASS;
					cmd_d.pass_byte = in_byte;
				end
			end
			PH_CLASS: begin
				class_d = in_byte;
				sum_a_d = in_byte;
				sum_b_d = in_byte;
				phase_d = PH_ID;
			end
			PH_ID: begin
				id_d    = in_byte;
				sum_a_d = add_a;
				sum_b_d = add_b;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_d   = {{(FRAME_LEN_W-BYTE_W){1'b0}}, in_byte};
				sum_a_d = add_a;
				sum_b_d = add_b;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d   = full_len;
				sum_a_d = add_a;
				sum_b_d = add_b;
				fill_d  = '0;
				if (full_len > MAX_LEN) begin
					// skip payload and both checksum bytes
					skip_d  = SKIP_W'(full_len) + SKIP_W'(2);
					phase_d = PH_SKIP;
				end else if (full_len == '0) begin
					phase_d = PH_CK_A;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				fill_d  = fill_inc;
				sum_a_d = add_a;
				sum_b_d = add_b;
				if (FRAME_LEN_W'(fill_inc) >= len_q) begin
					phase_d = PH_CK_A;
				end
			end
			PH_CK_A: begin
				recv_a_d = in_byte;
				phase_d  = PH_CK_B;
			end
			PH_CK_B: begin
				phase_d = PH_SYNC1;
				if (recv_a_q == sum_a_q && in_byte == sum_b_q) begin
					cmd_d.status      = ST_FRAME;
					cmd_d.msg_class   = class_q;
					cmd_d.msg_id      = id_q;
					cmd_d.payload_len = len_q[LEN_W-1:0];
					if (len_q != '0) begin
						cmd_d.kind = CMD_RUN;
					end
				end
			end
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == '0) begin
					phase_d         = PH_SYNC1;
					cmd_d.status    = ST_OVERSIZE;
					cmd_d.msg_class = class_q;
					cmd_d.msg_id    = id_q;
				end
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SYNC1;
			cmd_valid_q <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			cmd_valid_q <= 1'b1;
		end else if (cmd_take) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd_d;
			class_q  <= class_d;
			id_q     <= id_d;
			len_q    <= len_d;
			sum_a_q  <= sum_a_d;
			sum_b_q  <= sum_b_d;
			recv_a_q <= recv_a_d;
			fill_q   <= fill_d;
			skip_q   <= skip_d;
		end
	end

	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

	assign wr.en   = accept && (phase_q == PH_PAYLOAD);
	assign wr.addr = fill_q[IDX_W-1:0];
	assign wr.data = in_byte;

endmodule

@@ hw/rtl/ubxd_emitter.sv @@
// payload buffer and result emitter with registered output beat
module ubxd_emitter
	import ubxd_pkg::*;
#(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wr_t                wr,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_take,
	output logic               run_busy,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic [TUSER_W-1:0] m_tuser,
	output logic               m_tlast
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	typedef enum logic [1:0] {
		EM_IDLE = 2'b01,
		EM_RUN  = 2'b10
	} em_state_t;

	logic [BYTE_W-1:0]  mem [MAX_PAYLOAD];
	logic [BYTE_W-1:0]  rdata_q;

	em_state_t          state_q;
	logic               out_valid_q;
	logic               rd_ok_q;
	logic [IDX_W-1:0]   idx_q;
	logic [BYTE_W-1:0]  run_class_q;
	logic [BYTE_W-1:0]  run_id_q;
	logic [LEN_W-1:0]   run_len_q;

	status_t            out_status_q;
	logic [BYTE_W-1:0]  out_pass_q;
	logic [BYTE_W-1:0]  out_class_q;
	logic [BYTE_W-1:0]  out_id_q;
	logic [LEN_W-1:0]   out_len_q;
	logic               out_has_q;
	logic [BYTE_W-1:0]  out_pbyte_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic               out_last_q;

	logic               out_free;
	logic               take_single;
	logic               take_run;
	logic               load_run;
	logic               last_hit;

	// one read port, data registered; address is the run index
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		rdata_q <= mem[idx_q[AW-1:0]];
	end

	assign out_free    = !out_valid_q || m_tready;
	assign run_busy    = (state_q == EM_RUN);
	assign cmd_take    = (state_q == EM_IDLE) && cmd_valid && out_free;
	assign take_single = cmd_take && (cmd.kind == CMD_SINGLE);
	assign take_run    = cmd_take && (cmd.kind == CMD_RUN);
	assign load_run    = run_busy && rd_ok_q && out_free;
	assign last_hit    = ({1'b0, idx_q} + LEN_W'(1)) == run_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EM_IDLE;
			out_valid_q <= 1'b0;
			rd_ok_q     <= 1'b0;
			idx_q       <= '0;
		end else begin
			// read data is good once rdata_q has registered the settled index
			rd_ok_q <= run_busy && !load_run;
			if (take_single || load_run) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (take_run) begin
				state_q <= EM_RUN;
				idx_q   <= '0;
			end else if (load_run) begin
				idx_q <= idx_q + IDX_W'(1);
				if (last_hit) begin
					state_q <= EM_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_run) begin
			run_class_q <= cmd.msg_class;
			run_id_q    <= cmd.msg_id;
			run_len_q   <= cmd.payload_len;
		end
		if (take_single) begin
			out_status_q <= cmd.status;
			out_pass_q   <= cmd.pass_byte;
			out_class_q  <= cmd.msg_class;
			out_id_q     <= cmd.msg_id;
			out_len_q    <= cmd.payload_len;
			out_has_q    <= 1'b0;
			out_pbyte_q  <= '0;
			out_idx_q    <= '0;
			out_last_q   <= 1'b1;
		end else if (load_run) begin
			out_status_q <= ST_FRAME;
			out_pass_q   <= '0;
			out_class_q  <= run_class_q;
			out_id_q     <= run_id_q;
			out_len_q    <= run_len_q;
			out_has_q    <= 1'b1;
			out_pbyte_q  <= rdata_q;
			out_idx_q    <= idx_q;
			out_last_q   <= last_hit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{TDATA_PAD_W{1'b0}}, out_idx_q, out_pbyte_q, out_len_q,
		out_id_q, out_class_q, out_pass_q};
	assign m_tuser  = {out_has_q, out_status_q};
	assign m_tlast  = out_last_q;

endmodule

@@ hw/rtl/ubx_stream_deframer.sv @@
// top level of the ubx stream deframer: parser plus buffered result emitter
// a byte's single result beat passes the command register, then the output register
// no new byte is accepted while a command waits in its slot or a payload run is busy
// good frame: payload_len buffered beats with input held, or one beat if payload is empty
// reset: arst_n clears phase and handshake state at once; the payload buffer is not cleared
`include "assert_macros.svh"

module ubx_stream_deframer
	import ubxd_pkg::*;
#(
	parameter int MAX_PAYLOAD = 64,
	parameter int SYNC_FIRST  = 181,
	parameter int SYNC_SECOND = 98
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [BYTE_W-1:0]  s_tdata,   // in_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // pass_byte, msg_class, msg_id, payload_len,
	                                      // payload_byte, byte_index, zero pad
	output logic [TUSER_W-1:0] m_tuser,   // status, has_byte
	output logic               m_tlast
);

	logic cmd_valid;
	logic cmd_take;
	logic run_busy;
	cmd_t cmd;
	wr_t  wr;
	logic last_payload_beat;
	logic last_idx_ok;

	ubxd_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.SYNC_FIRST  (SYNC_FIRST),
		.SYNC_SECOND (SYNC_SECOND)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.run_busy  (run_busy),
		.cmd_take  (cmd_take),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.wr        (wr)
	);

	ubxd_emitter #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.run_busy  (run_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	assign last_payload_beat = m_tvalid && m_tlast && m_tuser[2];
	assign last_idx_ok       = (LEN_W'(m_tdata[44:39]) + LEN_W'(1)) == m_tdata[30:24];

	// buffer must not be written while a run reads it
	`ASSERT_NEVER(a_no_write_in_run, clk, arst_n, wr.en && run_busy, "buffer write during run")
	// a pending command is never lost
	`ASSERT_PROP(a_cmd_held, clk, arst_n, cmd_valid && !cmd_take |=> cmd_valid, "command dropped")
	// final payload beat sits at the last index of the payload
	`ASSERT_PROP(a_last_index, clk, arst_n, last_payload_beat |-> last_idx_ok, "bad last index")

endmodule
